>>> sv/mpbc_pkg.sv
`timescale 1ns / 1ps

package mpbc_pkg;

  localparam int Channels = 8;
  localparam int ChanW = 3;
  localparam int CountW = 16;
  localparam int RegIdxW = 2;
  localparam int InDataW = 8;
  localparam int OutDataW = 24;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SETUP    = 3'd1,
    PH_ACTIVE   = 3'd2,
    PH_INACTIVE = 3'd3,
    PH_WAIT     = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_ACT = 2'd0;
  localparam logic [1:0] KIND_INACT = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [RegIdxW-1:0] REG_MIN_ACTIVE = 2'd0;
  localparam logic [RegIdxW-1:0] REG_MAX_ACTIVE = 2'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_INACTIVE = 2'd2;

  localparam logic [CountW-1:0] MinActiveReset = 16'd50;
  localparam logic [CountW-1:0] MaxActiveReset = 16'd1000;
  localparam logic [CountW-1:0] MaxInactiveReset = 16'd500;

  typedef struct packed {
    phase_t            phase;
    logic [CountW-1:0] timer;
    logic [CountW-1:0] count;
  } chan_state_t;

  localparam chan_state_t ChanStateReset = '{phase: PH_IDLE, timer: '0, count: '0};

endpackage

>>> sv/multichannel_pulse_burst_counter.sv
`timescale 1ns / 1ps

// A reporting transfer is registered into the work stage when it is accepted, and its
// result is loaded into the output register when that stage advances.
// Throughput: one transfer per cycle unless a report waits on m_tready, set by the per-channel read-modify-write on the
// state memory; a write is forwarded to a read of the same channel that follows it.
// Reset: rst clears all channels to idle with zero timer and count through
// per-entry valid bits, and restores the register reset values.
module multichannel_pulse_burst_counter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mpbc_pkg::InDataW-1:0]    s_tdata,   // [2:0] channel_index
  input  logic [1:0]                      s_tuser,   // [1:0] kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mpbc_pkg::OutDataW-1:0]   m_tdata,   // [2:0] report_channel, [18:3] report_count
  input  logic                            cfg_we,
  input  logic [mpbc_pkg::RegIdxW-1:0]    cfg_addr,
  input  logic [mpbc_pkg::CountW-1:0]     cfg_wdata
);

  logic [mpbc_pkg::CountW-1:0] min_active_ticks;
  logic [mpbc_pkg::CountW-1:0] max_active_ticks;
  logic [mpbc_pkg::CountW-1:0] max_inactive_ticks;

  mpbc_pkg::chan_state_t state_mem [mpbc_pkg::Channels];
  logic [mpbc_pkg::Channels-1:0] entry_vld;

  logic                        s_accept;
  logic                        s1_valid;
  logic                        s1_adv;
  logic [mpbc_pkg::ChanW-1:0]  s1_ch;
  logic [1:0]                  s1_kind;
  mpbc_pkg::chan_state_t       rd_data;
  logic                        rd_vld;

  logic                        wr_valid;
  logic [mpbc_pkg::ChanW-1:0]  wr_ch;
  mpbc_pkg::chan_state_t       wr_data;

  mpbc_pkg::chan_state_t       cur;
  mpbc_pkg::chan_state_t       state_next;
  logic [mpbc_pkg::CountW-1:0] timer_inc;
  logic                        report;
  logic                        fwd_hit;

  logic [mpbc_pkg::ChanW-1:0]  in_ch;
  assign in_ch = s_tdata[mpbc_pkg::ChanW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_active_ticks <= mpbc_pkg::MinActiveReset;
      max_active_ticks <= mpbc_pkg::MaxActiveReset;
      max_inactive_ticks <= mpbc_pkg::MaxInactiveReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        mpbc_pkg::REG_MIN_ACTIVE: min_active_ticks <= cfg_wdata;
        mpbc_pkg::REG_MAX_ACTIVE: max_active_ticks <= cfg_wdata;
        mpbc_pkg::REG_MAX_INACTIVE: max_inactive_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_tready = !s1_valid || s1_adv;
  assign s_accept = s_tvalid && s_tready;
  assign s1_adv = s1_valid && (!report || !m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_ch <= in_ch;
      s1_kind <= s_tuser;
      rd_data <= state_mem[in_ch];
      rd_vld <= entry_vld[in_ch];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      state_mem[s1_ch] <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      wr_valid <= 1'b0;
    end else if (s1_adv) begin
      entry_vld[s1_ch] <= 1'b1;
      wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wr_ch <= s1_ch;
      wr_data <= state_next;
    end
  end

  assign fwd_hit = wr_valid && (wr_ch == s1_ch);

  always_comb begin
    if (fwd_hit) begin
      cur = wr_data;
    end else if (rd_vld) begin
      cur = rd_data;
    end else begin
      cur = mpbc_pkg::ChanStateReset;
    end
  end

  assign timer_inc = (cur.timer == mpbc_pkg::CountMax) ? cur.timer
                                                       : cur.timer + 1'b1;

  always_comb begin
    state_next = cur;
    case (cur.phase)
      mpbc_pkg::PH_SETUP: begin
        if (s1_kind == mpbc_pkg::KIND_INACT) begin
          state_next.phase = mpbc_pkg::PH_IDLE;
          state_next.timer = '0;
        end else if (s1_kind == mpbc_pkg::KIND_TICK) begin
          state_next.timer = timer_inc;
          if (timer_inc >= min_active_ticks) begin
            state_next.phase = mpbc_pkg::PH_ACTIVE;
            state_next.timer = '0;
          end
        end
      end
      mpbc_pkg::PH_ACTIVE: begin
        if (s1_kind == mpbc_pkg::KIND_INACT) begin
          if (cur.count != mpbc_pkg::CountMax) begin
            state_next.count = cur.count + 1'b1;
          end
          state_next.phase = mpbc_pkg::PH_INACTIVE;
          state_next.timer = '0;
        end else if (s1_kind == mpbc_pkg::KIND_TICK) begin
          state_next.timer = timer_inc;
          if (timer_inc >= max_active_ticks) begin
            state_next.phase = mpbc_pkg::PH_WAIT;
            state_next.timer = '0;
          end
        end
      end
      mpbc_pkg::PH_INACTIVE: begin
        if (s1_kind == mpbc_pkg::KIND_ACT) begin
          state_next.phase = mpbc_pkg::PH_SETUP;
          state_next.timer = '0;
        end else if (s1_kind == mpbc_pkg::KIND_TICK) begin
          state_next.timer = timer_inc;
          if (timer_inc >= max_inactive_ticks) begin
            state_next.phase = mpbc_pkg::PH_IDLE;
            state_next.timer = '0;
          end
        end
      end
      mpbc_pkg::PH_WAIT: begin
        if (s1_kind == mpbc_pkg::KIND_INACT) begin
          state_next.phase = mpbc_pkg::PH_IDLE;
          state_next.timer = '0;
        end
      end
      default: begin
        if (s1_kind == mpbc_pkg::KIND_ACT) begin
          state_next.count = '0;
          state_next.phase = mpbc_pkg::PH_SETUP;
          state_next.timer = '0;
        end
      end
    endcase
  end

  always_comb begin
    report = 1'b0;
    case (cur.phase)
      mpbc_pkg::PH_INACTIVE: begin
        report = s1_valid && (s1_kind == mpbc_pkg::KIND_TICK)
                 && (timer_inc >= max_inactive_ticks);
      end
      default: report = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && report) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && report) begin
      m_tdata <= {5'b0, cur.count, s1_ch};
    end
  end

`ifndef SYNTHESIS
  a_report_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && report) |=> m_tvalid)
    else $error("reporting transfer did not load the output register");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled while the work stage is empty");

  a_report_from_inactive: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && report) |-> (cur.phase == mpbc_pkg::PH_INACTIVE
                            && state_next.phase == mpbc_pkg::PH_IDLE))
    else $error("report raised outside the end of an inactive gap");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (entry_vld[wr_ch] && wr_valid))
    else $error("written channel entry not marked valid");
`endif

endmodule
